[src/ptkm_pkg.sv]
// ----------------------------------------------------------------------------
// Packed trie keyword match package
// Shared constants, operation codes and item types.
// ----------------------------------------------------------------------------
package ptkm_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int FIELD_W     = 8;
    localparam int PTR_W       = ((ADDR_W > FIELD_W) ? ADDR_W : FIELD_W) + 1;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_CHAR = 2'd1;
    localparam logic [1:0] OP_END  = 2'd2;

    localparam logic [7:0] BYTE_FAIL   = 8'hff;
    localparam logic [7:0] BYTE_NEXT   = 8'hfe;
    localparam logic [7:0] BRANCH_FLAG = 8'h80;
    localparam logic [7:0] CHAR_MASK   = 8'h7f;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] table_addr;
        logic [7:0] table_byte;
        logic [7:0] character;
    } t_in_item;

    typedef struct packed {
        logic [7:0] token;
        logic       found;
    } t_out_item;

    typedef struct packed {
        logic       start;
        logic       is_end;
        logic [7:0] character;
    } t_walk_req;

    typedef struct packed {
        logic       idle;
        logic       done;
        logic [7:0] token;
        logic       found;
    } t_walk_rsp;

endpackage

[src/ptkm_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ptkm_ram #(
    parameter int W = 8,
    parameter int D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/ptkm_walker.sv]
// ----------------------------------------------------------------------------
// Packed trie walker
// Sequencer that steps the walk pointer through the table with one shared
// pointer adder, one table read per entry visited.
// ----------------------------------------------------------------------------
module ptkm_walker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [7:0]                   i_cfg_wdata,
    input  ptkm_pkg::t_walk_req          i_req,
    input  logic                         i_take,
    input  logic [7:0]                   i_rd_data,
    output logic [ptkm_pkg::ADDR_W-1:0]  o_rd_addr,
    output ptkm_pkg::t_walk_rsp          o_rsp
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RD      = 4'd1;
    localparam logic [3:0] S_DAT     = 4'd2;
    localparam logic [3:0] S_SKP_RD  = 4'd3;
    localparam logic [3:0] S_SKP     = 4'd4;
    localparam logic [3:0] S_END_RD  = 4'd5;
    localparam logic [3:0] S_END_DAT = 4'd6;
    localparam logic [3:0] S_TOK_RD  = 4'd7;
    localparam logic [3:0] S_TOK     = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    logic [3:0]                  r_state, n_state;
    logic [ptkm_pkg::PTR_W-1:0]  r_ptr, n_ptr;
    logic                        r_failed, n_failed;
    logic [7:0]                  r_start;
    logic [7:0]                  r_ch, n_ch;
    logic [7:0]                  r_tok, n_tok;
    logic                        r_found, n_found;
    logic [ptkm_pkg::PTR_W-1:0]  addend;
    logic [ptkm_pkg::PTR_W-1:0]  ptr_sum;
    logic                        in_range;

    // Whenever the pointer advances, it moves by the addend plus one.
    assign ptr_sum  = r_ptr + addend + ptkm_pkg::PTR_W'(1);
    assign in_range = r_ptr < ptkm_pkg::PTR_W'(ptkm_pkg::TABLE_DEPTH);

    always_comb begin
        n_state  = r_state;
        n_ptr    = r_ptr;
        n_failed = r_failed;
        n_ch     = r_ch;
        n_tok    = r_tok;
        n_found  = r_found;
        addend   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_ch    = i_req.character;
                    n_state = i_req.is_end ? S_END_RD : S_RD;
                end
            end
            S_RD: begin
                if (r_failed) begin
                    n_state = S_IDLE;
                end else if (!in_range) begin
                    n_failed = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_DAT;
                end
            end
            S_DAT: begin
                if (i_rd_data == ptkm_pkg::BYTE_FAIL) begin
                    n_failed = 1'b1;
                    n_state  = S_IDLE;
                end else if (i_rd_data == ptkm_pkg::BYTE_NEXT) begin
                    addend  = ptkm_pkg::PTR_W'(1);
                    n_ptr   = ptr_sum;
                    n_state = S_RD;
                end else if ((i_rd_data & ptkm_pkg::BRANCH_FLAG) != 8'd0) begin
                    if (r_ch == (i_rd_data & ptkm_pkg::CHAR_MASK)) begin
                        addend  = ptkm_pkg::PTR_W'(1);
                        n_ptr   = ptr_sum;
                        n_state = S_IDLE;
                    end else begin
                        n_ptr   = ptr_sum;
                        n_state = S_SKP_RD;
                    end
                end else if (i_rd_data == r_ch) begin
                    n_ptr   = ptr_sum;
                    n_state = S_IDLE;
                end else begin
                    n_failed = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_SKP_RD: begin
                if (!in_range) begin
                    n_failed = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_SKP;
                end
            end
            S_SKP: begin
                addend  = ptkm_pkg::PTR_W'(i_rd_data);
                n_ptr   = ptr_sum;
                n_state = S_RD;
            end
            S_END_RD: begin
                if (r_failed || !in_range) begin
                    n_tok   = 8'd0;
                    n_found = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_state = S_END_DAT;
                end
            end
            S_END_DAT: begin
                if (i_rd_data inside {ptkm_pkg::BYTE_FAIL, ptkm_pkg::BYTE_NEXT}) begin
                    n_ptr   = ptr_sum;
                    n_state = S_TOK_RD;
                end else begin
                    n_tok   = 8'd0;
                    n_found = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_TOK_RD: begin
                if (!in_range) begin
                    n_tok   = 8'd0;
                    n_found = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_state = S_TOK;
                end
            end
            S_TOK: begin
                n_tok   = i_rd_data;
                n_found = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_take) begin
                    n_ptr    = ptkm_pkg::PTR_W'(r_start);
                    n_failed = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ptr    <= '0;
            r_failed <= 1'b0;
            r_start  <= 8'd0;
        end else if (i_cfg_we) begin
            r_state  <= n_state;
            r_start  <= i_cfg_wdata;
            r_ptr    <= ptkm_pkg::PTR_W'(i_cfg_wdata);
            r_failed <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_failed <= n_failed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch    <= n_ch;
        r_tok   <= n_tok;
        r_found <= n_found;
    end

    assign o_rd_addr   = r_ptr[ptkm_pkg::ADDR_W-1:0];
    assign o_rsp.idle  = (r_state == S_IDLE);
    assign o_rsp.done  = (r_state == S_DONE);
    assign o_rsp.token = r_tok;
    assign o_rsp.found = r_found;

    a_dat_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DAT) |-> (!r_failed && r_ptr < ptkm_pkg::PTR_W'(ptkm_pkg::TABLE_DEPTH)))
        else $error("table byte evaluated for a failed word or out-of-range pointer");

    a_miss_token_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_found) |-> (r_tok == 8'd0))
        else $error("unmatched word carries a nonzero token");

    a_restart_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && i_take) |=>
            (r_state == S_IDLE && !r_failed && r_ptr == ptkm_pkg::PTR_W'(r_start)))
        else $error("walk not restarted after the result was taken");

endmodule

[src/packed_trie_keyword_match.sv]
// ----------------------------------------------------------------------------
// Packed trie keyword match
// Loads a packed trie keyword table and matches words against it, one
// character per item, giving the keyword token at each end item.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      i_in_valid / o_in_ready    i_in_item  (t_in_item)
//   out      output     o_out_valid / i_out_ready  o_out_item (t_out_item)
//   cfg      input      i_cfg_we                   i_cfg_wdata (table start)
//
// A load item is written to the table when it is accepted. A character item
// reads table entries through the single table read port and the shared
// pointer adder, skipping branches that do not match; once a word has failed,
// its character items read no table entries. An end item reads the token
// entry when a token is found, then waits for a free output register. Reset
// is synchronous and needs no clearing pass. A result waiting in the output
// register stalls the next end item, and with it every later item.
// ----------------------------------------------------------------------------
module packed_trie_keyword_match (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ptkm_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ptkm_pkg::t_out_item  o_out_item,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_wdata
);

    logic                         in_accept;
    logic                         take;
    logic                         load_we;
    logic [ptkm_pkg::PTR_W-1:0]   load_addr;
    logic [ptkm_pkg::ADDR_W-1:0]  rd_addr;
    logic [7:0]                   rd_data;
    ptkm_pkg::t_walk_req          walk_req;
    ptkm_pkg::t_walk_rsp          walk_rsp;
    logic                         r_out_valid;
    ptkm_pkg::t_out_item          r_out_item;

    assign o_in_ready = walk_rsp.idle;
    assign in_accept  = i_in_valid && o_in_ready;
    assign load_addr  = ptkm_pkg::PTR_W'(i_in_item.table_addr);
    assign load_we    = in_accept && (i_in_item.operation == ptkm_pkg::OP_LOAD)
                        && (load_addr < ptkm_pkg::PTR_W'(ptkm_pkg::TABLE_DEPTH));

    assign walk_req.start     = in_accept && ((i_in_item.operation == ptkm_pkg::OP_CHAR)
                                || (i_in_item.operation == ptkm_pkg::OP_END));
    assign walk_req.is_end    = (i_in_item.operation == ptkm_pkg::OP_END);
    assign walk_req.character = i_in_item.character;

    assign take = walk_rsp.done && (!r_out_valid || i_out_ready);

    ptkm_ram #(
        .W (8),
        .D (ptkm_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (load_addr[ptkm_pkg::ADDR_W-1:0]),
        .i_wdata (i_in_item.table_byte),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    ptkm_walker u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (walk_req),
        .i_take      (take),
        .i_rd_data   (rd_data),
        .o_rd_addr   (rd_addr),
        .o_rsp       (walk_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_item.token <= walk_rsp.token;
            r_out_item.found <= walk_rsp.found;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
